@@ rtl/dtfp_pkg.sv @@
// dtfp_pkg: shared types and constants for the decimal text to fixed point block
// no dependencies; used by dtfp_accum, dtfp_conv and the top level
`default_nettype none

package dtfp_pkg;

  // character codes
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChPoint   = 8'h2E;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChNewline = 8'h0A;

  // configuration register indexes
  localparam logic RegFracBits = 1'b0;
  localparam logic RegIntBits  = 1'b1;

  // reset values of the configuration registers
  localparam logic [5:0] FracBitsReset = 6'd16;
  localparam logic [4:0] IntBitsReset  = 5'd15;

  // fraction digits kept per record
  localparam logic [4:0] MaxFracDigits = 5'd18;

  // integer accumulator saturates at 2^32
  localparam logic [32:0] IntAccCap = 33'h1_0000_0000;

  // input item
  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_input;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [63:0] word;
    logic        overflow;
  } out_item_t;

  // accumulated record handed to the converter
  typedef struct packed {
    logic [32:0] int_acc;
    logic [59:0] frac_acc;
    logic [59:0] scale;
    logic        neg;
    logic        ovf;
  } rec_t;

  // control state of the top level
  typedef enum logic {
    StIdle,
    StConv
  } state_e;

endpackage

`default_nettype wire

@@ rtl/dtfp_accum.sv @@
// dtfp_accum: parses one character per take_i cycle into sign, int and frac accumulators
// depends on dtfp_pkg
`default_nettype none

module dtfp_accum (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [7:0]       symbol_i,
  input  wire logic             last_i,
  output dtfp_pkg::rec_t        rec_o,
  output logic                  emit_o
);

  dtfp_pkg::rec_t rec_q, rec_d;
  logic [4:0]  digits_q, digits_d;
  logic        point_q, point_d;
  logic        started_q, started_d;

  logic        is_digit, is_point, is_minus, is_nl, clear;
  logic [3:0]  digit;
  logic [36:0] int_mul;
  logic [63:0] frac_mul;
  logic [63:0] scale_mul;

  // character classes
  assign is_digit = (symbol_i >= dtfp_pkg::ChZero) && (symbol_i <= dtfp_pkg::ChNine);
  assign is_point = (symbol_i == dtfp_pkg::ChPoint);
  assign is_minus = (symbol_i == dtfp_pkg::ChMinus);
  assign is_nl    = (symbol_i == dtfp_pkg::ChNewline);
  assign digit    = 4'(symbol_i - dtfp_pkg::ChZero);

  // times ten as two shifts and an add
  assign int_mul   = ({4'b0, rec_q.int_acc} << 3) + ({4'b0, rec_q.int_acc} << 1)
                     + {33'b0, digit};
  assign frac_mul  = ({4'b0, rec_q.frac_acc} << 3) + ({4'b0, rec_q.frac_acc} << 1)
                     + {60'b0, digit};
  assign scale_mul = ({4'b0, rec_q.scale} << 3) + ({4'b0, rec_q.scale} << 1);

  // record after this character
  always_comb begin
    rec_d     = rec_q;
    digits_d  = digits_q;
    point_d   = point_q;
    started_d = started_q | is_digit | is_point | is_minus;
    if (is_digit) begin
      if (!point_q) begin
        rec_d.int_acc = (int_mul > {4'b0, dtfp_pkg::IntAccCap}) ? dtfp_pkg::IntAccCap
                                                                 : int_mul[32:0];
      end else if (digits_q < dtfp_pkg::MaxFracDigits) begin
        rec_d.frac_acc = frac_mul[59:0];
        rec_d.scale    = scale_mul[59:0];
        digits_d       = digits_q + 5'd1;
      end else begin
        rec_d.ovf = 1'b1;
      end
    end
    if (is_point) point_d = 1'b1;
    if (is_minus) rec_d.neg = 1'b1;
  end

  assign emit_o = is_nl || (last_i && started_d);
  assign clear  = emit_o || last_i;
  assign rec_o  = rec_d;

  // accumulator registers, each record starts from zero with a scale of one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q.int_acc  <= '0;
      rec_q.frac_acc <= '0;
      rec_q.scale    <= 60'd1;
      rec_q.neg      <= 1'b0;
      rec_q.ovf      <= 1'b0;
      digits_q       <= '0;
      point_q        <= 1'b0;
      started_q      <= 1'b0;
    end else if (take_i) begin
      if (clear) begin
        rec_q.int_acc  <= '0;
        rec_q.frac_acc <= '0;
        rec_q.scale    <= 60'd1;
        rec_q.neg      <= 1'b0;
        rec_q.ovf      <= 1'b0;
        digits_q       <= '0;
        point_q        <= 1'b0;
        started_q      <= 1'b0;
      end else begin
        rec_q     <= rec_d;
        digits_q  <= digits_d;
        point_q   <= point_d;
        started_q <= started_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/dtfp_conv.sv @@
// dtfp_conv: bit-serial fraction converter, shifts one fraction bit per cycle into the word
// depends on dtfp_pkg
`default_nettype none

module dtfp_conv (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire dtfp_pkg::rec_t   rec_i,
  input  wire logic [5:0]       frac_bits_i,
  input  wire logic [4:0]       int_bits_i,
  output logic                  done_o,
  output logic [63:0]           word_o,
  output logic                  overflow_o
);

  logic [59:0] rem_q, rem_d;
  logic [59:0] scale_q;
  logic [62:0] mag_q, mag_d;
  logic [63:0] mask_q, mask_d;
  logic [5:0]  cnt_q;
  logic        neg_q, ovf_q;

  logic [5:0]  fb_sat, ib_sat;
  logic [30:0] int_max;
  logic        ovf_start;
  logic [60:0] rem2;
  logic        ge, out_bit;

  // format limits, saturated at start
  always_comb begin
    priority if (frac_bits_i == 6'd0)  fb_sat = 6'd1;
    else if (frac_bits_i > 6'd32)      fb_sat = 6'd32;
    else                               fb_sat = frac_bits_i;
    ib_sat = (int_bits_i == 5'd0) ? 6'd1 : {1'b0, int_bits_i};
  end

  assign int_max   = 31'((32'd1 << ib_sat) - 32'd1);
  assign ovf_start = rec_i.ovf || (rec_i.int_acc > {2'b0, int_max});

  // one restoring step: double the remainder and compare against the scale
  assign rem2    = {rem_q, 1'b0};
  assign ge      = (rem2 >= {1'b0, scale_q});
  assign out_bit = ovf_q | ge;
  assign rem_d   = ge ? 60'(rem2 - {1'b0, scale_q}) : rem2[59:0];
  assign mag_d   = {mag_q[61:0], out_bit};
  assign mask_d  = {mask_q[62:0], 1'b1};

  assign done_o = (cnt_q == 6'd0);

  // converter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      neg_q <= 1'b0;
      ovf_q <= 1'b0;
    end else if (start_i) begin
      cnt_q <= fb_sat;
      neg_q <= rec_i.neg;
      ovf_q <= ovf_start;
    end else if (!done_o) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= rec_i.frac_acc;
      scale_q <= rec_i.scale;
      mag_q   <= {32'b0, ovf_start ? int_max : rec_i.int_acc[30:0]};
      mask_q  <= 64'((64'd1 << (ib_sat + 6'd1)) - 64'd1);
    end else if (!done_o) begin
      rem_q  <= rem_d;
      mag_q  <= mag_d;
      mask_q <= mask_d;
    end
  end

  // ones' complement for negative values
  assign word_o     = neg_q ? (~{1'b0, mag_q} & mask_q) : {1'b0, mag_q};
  assign overflow_o = ovf_q;

endmodule

`default_nettype wire

@@ rtl/decimal_text_to_fixed_point_top.sv @@
// Decimal text to fixed point converter. Takes one ASCII character per cycle while
// in_ready_o is high and turns each line such as -12.375 into a word of a sign bit,
// int_bits integer bits and frac_bits fraction bits (negative values inverted bit
// for bit). A newline, or the last character of the input, starts the bit-serial
// fraction converter, which produces one fraction bit per cycle, with frac_bits
// taken as 1 to 32 (0 counts as 1, anything above 32 as 32); the next character is
// taken only once the converter is done and the output register is free.
// depends on dtfp_pkg, dtfp_accum and dtfp_conv
`default_nettype none

module decimal_text_to_fixed_point_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [5:0]          cfg_data_i,
  // character items
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire dtfp_pkg::in_item_t  in_item_i,
  // result items
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dtfp_pkg::out_item_t      out_item_o
);

  dtfp_pkg::state_e    state_q, state_d;
  logic [5:0]          frac_bits_q;
  logic [4:0]          int_bits_q;
  logic                out_valid_q;
  dtfp_pkg::out_item_t out_q;

  dtfp_pkg::rec_t      rec;
  logic                emit, take, conv_start, conv_done, out_load, out_free;
  logic [63:0]         conv_word;
  logic                conv_ovf;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_bits_q <= dtfp_pkg::FracBitsReset;
      int_bits_q  <= dtfp_pkg::IntBitsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dtfp_pkg::RegFracBits: frac_bits_q <= cfg_data_i;
        dtfp_pkg::RegIntBits:  int_bits_q  <= cfg_data_i[4:0];
        default:               frac_bits_q <= frac_bits_q;
      endcase
    end
  end

  dtfp_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .symbol_i (in_item_i.symbol),
    .last_i   (in_item_i.end_of_input),
    .rec_o    (rec),
    .emit_o   (emit)
  );

  dtfp_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (conv_start),
    .rec_i       (rec),
    .frac_bits_i (frac_bits_q),
    .int_bits_i  (int_bits_q),
    .done_o      (conv_done),
    .word_o      (conv_word),
    .overflow_o  (conv_ovf)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtfp_pkg::StIdle: if (take && emit) state_d = dtfp_pkg::StConv;
      dtfp_pkg::StConv: if (conv_done && out_free) state_d = dtfp_pkg::StIdle;
      default:          state_d = dtfp_pkg::StIdle;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      dtfp_pkg::StIdle: in_ready_o = 1'b1;
      dtfp_pkg::StConv: out_load   = conv_done && out_free;
      default:          in_ready_o = 1'b0;
    endcase
  end

  assign take       = in_valid_i && in_ready_o;
  assign conv_start = take && emit;

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtfp_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.word     <= conv_word;
      out_q.overflow <= conv_ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
